// ----- sv/sync_frame_receiver_crc16_top_assert.svh -----
// Assertion macros shared by the frame receiver checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef SYNC_FRAME_RECEIVER_CRC16_TOP_ASSERT_SVH
`define SYNC_FRAME_RECEIVER_CRC16_TOP_ASSERT_SVH

// Clocked assertion, masked while reset is high.
`define SFR16_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define SFR16_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/sfr16_pkg.sv -----
// Shared types, constants and the CRC-16 byte update for the frame receiver.
// No dependencies.
`timescale 1ns / 1ps
package sfr16_pkg;

   localparam int CsrAddrWidth = 3;
   localparam int CsrDataWidth = 32;

   localparam logic [7:0]  HdrFirst  = 8'h55;
   localparam logic [7:0]  HdrSecond = 8'hAA;
   localparam logic [7:0]  CrcBypass = 8'hEE;
   localparam logic [15:0] CrcPoly   = 16'h8408;

   typedef enum logic [2:0] {
      PH_HUNT1 = 3'd0,
      PH_HUNT2 = 3'd1,
      PH_CMD   = 3'd2,
      PH_LENH  = 3'd3,
      PH_LENL  = 3'd4,
      PH_DATA  = 3'd5,
      PH_CRCH  = 3'd6,
      PH_CRCL  = 3'd7
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_BYPASS   = 2'd1,
      ST_CRC_ERR  = 2'd2,
      ST_CMD_MISS = 2'd3
   } status_type;

   typedef enum logic {
      KIND_PAYLOAD = 1'b0,
      KIND_VERDICT = 1'b1
   } kind_type;

   // Register index, taken from paddr[2]
   typedef enum logic {
      REG_CHECK_COMMAND    = 1'b0,
      REG_EXPECTED_COMMAND = 1'b1
   } reg_index_type;

   // Reflected CRC-16, one byte folded in, eight bit steps unrolled
   function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// ----- sv/sfr16_if.sv -----
// Valid/ready channel interfaces for the frame receiver: input bytes and results.
// No dependencies.
`timescale 1ns / 1ps
interface sfr16_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfr16_rsp_if;
   logic        valid;
   logic        ready;
   logic        out_kind;
   logic [7:0]  payload_byte;
   logic [7:0]  frame_command;
   logic [15:0] frame_length;
   logic [1:0]  frame_status;
   logic        last;

   modport source (output valid, output out_kind, output payload_byte, output frame_command,
                   output frame_length, output frame_status, output last, input ready);
   modport sink   (input valid, input out_kind, input payload_byte, input frame_command,
                   input frame_length, input frame_status, input last, output ready);
endinterface

// ----- sv/sync_frame_receiver_crc16_top.sv -----
// Header/length/CRC-16 frame receiver: deframes a byte stream, emits payload and verdicts.
// Depends on sfr16_pkg and the channel interfaces in sfr16_if.sv.
//
//   channel | dir | transfer when          | payload
//   req_ch  | in  | valid & ready          | rx_byte
//   rsp_ch  | out | valid & ready          | kind, byte, command, length, status, last
//   csr     | in  | psel&penable&pwrite    | check_command @0x0, expected_command @0x4
//
// One byte per cycle while not stalled: each byte is decoded, and payload bytes folded into
// the CRC, in its transfer cycle; any result lands in the output register at the next edge.
// The output register holds a stalled result; req_ch.ready is low only while that
// register is full and rsp_ch.ready is low.
// Synchronous reset returns to header hunt and empties the output register.
`timescale 1ns / 1ps
module sync_frame_receiver_crc16_top (
   input  logic                                clock,
   input  logic                                reset,
   sfr16_req_if.sink                           req_ch,
   sfr16_rsp_if.source                         rsp_ch,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [sfr16_pkg::CsrAddrWidth-1:0]  paddr,
   input  logic [sfr16_pkg::CsrDataWidth-1:0]  pwdata,
   output logic [sfr16_pkg::CsrDataWidth-1:0]  prdata,
   output logic                                pready
);
   import sfr16_pkg::*;

   // configuration
   logic       check_command_ff;
   logic [7:0] expected_command_ff;
   logic       csr_write;
   reg_index_type csr_index;

   // frame state
   phase_type   phase_ff, phase_in;
   logic [7:0]  cmd_hold_ff, cmd_hold_in;
   logic [15:0] len_hold_ff, len_hold_in;
   logic [15:0] bytes_left_ff, bytes_left_in;
   logic [15:0] crc_run_ff, crc_run_in;
   logic [7:0]  crc_high_ff, crc_high_in;

   // result
   logic        res_fire;
   kind_type    res_kind;
   logic [7:0]  res_byte;
   status_type  res_status;
   logic [15:0] rx_crc;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_kind_ff;
   logic [7:0]  rsp_byte_ff;
   logic [7:0]  rsp_cmd_ff;
   logic [15:0] rsp_len_ff;
   logic [1:0]  rsp_status_ff;

   logic        accept;
   logic [7:0]  b;

   assign b      = req_ch.rx_byte;
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept = req_ch.valid && req_ch.ready;

   // ---------------- configuration port ----------------
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = reg_index_type'(paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         check_command_ff    <= 1'b0;
         expected_command_ff <= 8'h00;
      end else if (csr_write) begin
         case (csr_index)
            REG_CHECK_COMMAND:    check_command_ff    <= pwdata[0];
            REG_EXPECTED_COMMAND: expected_command_ff <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_CHECK_COMMAND:    prdata = {{(CsrDataWidth-1){1'b0}}, check_command_ff};
         REG_EXPECTED_COMMAND: prdata = {{(CsrDataWidth-8){1'b0}}, expected_command_ff};
         default:              prdata = '0;
      endcase
   end

   // ---------------- next phase ----------------
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         PH_HUNT1: if (b == HdrFirst) phase_in = PH_HUNT2;
         PH_HUNT2: begin
            if (b == HdrSecond)     phase_in = PH_CMD;
            else if (b != HdrFirst) phase_in = PH_HUNT1;
         end
         PH_CMD:   phase_in = PH_LENH;
         PH_LENH:  phase_in = PH_LENL;
         PH_LENL:  phase_in = ({len_hold_ff[15:8], b} == 16'h0000) ? PH_CRCH : PH_DATA;
         PH_DATA:  if (bytes_left_ff == 16'h0001) phase_in = PH_CRCH;
         PH_CRCH:  phase_in = PH_CRCL;
         PH_CRCL:  phase_in = PH_HUNT1;
         default:  phase_in = PH_HUNT1;
      endcase
   end

   // ---------------- datapath and result ----------------
   assign rx_crc = {crc_high_ff, b};

   always_comb begin
      cmd_hold_in   = cmd_hold_ff;
      len_hold_in   = len_hold_ff;
      bytes_left_in = bytes_left_ff;
      crc_run_in    = crc_run_ff;
      crc_high_in   = crc_high_ff;
      res_fire      = 1'b0;
      res_kind      = KIND_PAYLOAD;
      res_byte      = 8'h00;
      res_status    = ST_OK;
      case (phase_ff)
         PH_CMD: begin
            cmd_hold_in = b;
            crc_run_in  = 16'h0000;
         end
         PH_LENH: len_hold_in = {b, 8'h00};
         PH_LENL: begin
            len_hold_in   = {len_hold_ff[15:8], b};
            bytes_left_in = {len_hold_ff[15:8], b};
         end
         PH_DATA: begin
            crc_run_in    = crc_fold(crc_run_ff, b);
            bytes_left_in = bytes_left_ff - 16'd1;
            res_fire      = 1'b1;
            res_byte      = b;
         end
         PH_CRCH: crc_high_in = b;
         PH_CRCL: begin
            res_fire = 1'b1;
            res_kind = KIND_VERDICT;
            if (crc_high_ff == CrcBypass && b == CrcBypass) res_status = ST_BYPASS;
            else if (rx_crc != crc_run_ff)                  res_status = ST_CRC_ERR;
            // command mismatch overrides any CRC outcome
            if (check_command_ff && cmd_hold_ff != expected_command_ff)
               res_status = ST_CMD_MISS;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT1;
      end else if (accept) begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_hold_ff   <= cmd_hold_in;
         len_hold_ff   <= len_hold_in;
         bytes_left_ff <= bytes_left_in;
         crc_run_ff    <= crc_run_in;
         crc_high_ff   <= crc_high_in;
      end
   end

   // ---------------- output register ----------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept)            rsp_valid_in = res_fire;
      else if (rsp_ch.ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && res_fire) begin
         rsp_kind_ff   <= res_kind;
         rsp_byte_ff   <= res_byte;
         rsp_cmd_ff    <= cmd_hold_ff;
         rsp_len_ff    <= len_hold_ff;
         rsp_status_ff <= res_status;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.out_kind      = rsp_kind_ff;
   assign rsp_ch.payload_byte  = rsp_byte_ff;
   assign rsp_ch.frame_command = rsp_cmd_ff;
   assign rsp_ch.frame_length  = rsp_len_ff;
   assign rsp_ch.frame_status  = rsp_status_ff;
   assign rsp_ch.last          = rsp_kind_ff;

endmodule

// ----- sv/sfr16_checker.sv -----
// Port-level checker for the frame receiver, bound to the top level.
// Depends on sfr16_pkg and sync_frame_receiver_crc16_top_assert.svh.
`timescale 1ns / 1ps
`include "sync_frame_receiver_crc16_top_assert.svh"
module sfr16_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       out_kind,
   input logic [7:0] payload_byte,
   input logic [1:0] frame_status,
   input logic       last
);
   import sfr16_pkg::*;

   // a result that waits is still offered on the next cycle
   `SFR16_ASSERT(a_rsp_hold, clock, reset,
      rsp_valid && !rsp_ready |=> rsp_valid,
      "result dropped while stalled")

   // a new result only follows an input transfer
   `SFR16_ASSERT(a_rsp_cause, clock, reset,
      rsp_valid && !$past(rsp_valid) |-> $past(req_valid && req_ready),
      "result without input transfer")

   // input side never blocks while the output register is empty
   `SFR16_ASSERT(a_no_idle_stall, clock, reset,
      !rsp_valid |-> req_ready,
      "input stalled with empty output")

   // verdicts close the frame and carry no byte; payload items carry no status
   `SFR16_ASSERT(a_item_shape, clock, reset,
      rsp_valid |-> (last == out_kind) &&
         (out_kind == KIND_VERDICT ? payload_byte == 8'h00 : frame_status == ST_OK),
      "malformed result item")

   // nothing is offered in the cycle after a reset edge
   `SFR16_ASSERT_ALWAYS(a_reset_empty, clock,
      reset |=> !rsp_valid,
      "result offered after reset")

endmodule

bind sync_frame_receiver_crc16_top sfr16_checker u_sfr16_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .out_kind     (rsp_ch.out_kind),
   .payload_byte (rsp_ch.payload_byte),
   .frame_status (rsp_ch.frame_status),
   .last         (rsp_ch.last)
);

// ----- verif/sync_frame_receiver_crc16_top_test.sv -----
// Self-checking bench for the header/length/CRC-16 frame receiver.
// Needs sfr16_pkg, the channel interfaces in sfr16_if.sv and sync_frame_receiver_crc16_top.
// A local deframer model predicts payload bytes and frame verdicts, a monitor compares them.
`timescale 1ns / 1ps
module sync_frame_receiver_crc16_top_test;
   import sfr16_pkg::*;

   localparam int unsigned IdleLimit  = 3000;
   localparam int unsigned LongHold   = 400;
   localparam int unsigned MaxReports = 40;
   localparam int unsigned PhaseBytes = 75;

   typedef enum logic [1:0] {
      CRC_GOOD,
      CRC_BAD,
      CRC_SKIP,
      CRC_HALF_SKIP
   } crc_tail_type;

   typedef struct {
      kind_type    kind;
      logic [7:0]  payload;
      logic [7:0]  command;
      logic [15:0] length;
      status_type  status;
      logic        last;
   } frame_out_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                    psel    = 1'b0;
   logic                    penable = 1'b0;
   logic                    pwrite  = 1'b0;
   logic [CsrAddrWidth-1:0] paddr   = '0;
   logic [CsrDataWidth-1:0] pwdata  = '0;
   logic [CsrDataWidth-1:0] prdata;
   logic                    pready;

   sfr16_req_if req_bus ();
   sfr16_rsp_if rsp_bus ();

   sync_frame_receiver_crc16_top dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_bus),
      .rsp_ch  (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always #5 clock = ~clock;

   // deframer model state and its copy of the registers
   phase_type   rx_phase    = PH_HUNT1;
   logic [7:0]  held_cmd    = '0;
   logic [15:0] held_len    = '0;
   logic [15:0] remaining   = '0;
   logic [15:0] crc_acc     = '0;
   logic [7:0]  crc_hi_byte = '0;
   logic        chk_cmd_en  = 1'b0;
   logic [7:0]  want_cmd    = '0;

   logic [7:0]     rx_stream [$];
   frame_out_type  deframed_due [$];

   int unsigned bytes_pushed   = 0;
   int unsigned bytes_issued   = 0;
   int unsigned bytes_taken    = 0;
   int unsigned mismatch_count = 0;
   int unsigned quiet_cycles   = 0;
   int unsigned hold_asked     = 0;
   int unsigned hold_seen      = 0;
   bit          fast_send      = 1'b0;

   // reflected CRC-16, data bits taken LSB first
   function automatic logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] data);
      logic [15:0] acc;
      logic        fb;
      acc = crc;
      for (int i = 0; i < 8; i++) begin
         fb  = acc[0] ^ data[i];
         acc = acc >> 1;
         if (fb) acc = acc ^ CrcPoly;
      end
      return acc;
   endfunction

   function automatic void deframe_byte(logic [7:0] b);
      frame_out_type item;
      status_type    verdict;
      case (rx_phase)
         PH_HUNT1: begin
            if (b == HdrFirst) rx_phase = PH_HUNT2;
         end
         PH_HUNT2: begin
            // a second 0x55 is a fresh header start
            if (b == HdrSecond) rx_phase = PH_CMD;
            else if (b != HdrFirst) rx_phase = PH_HUNT1;
         end
         PH_CMD: begin
            held_cmd = b;
            crc_acc  = '0;
            rx_phase = PH_LENH;
         end
         PH_LENH: begin
            held_len = {b, 8'h00};
            rx_phase = PH_LENL;
         end
         PH_LENL: begin
            held_len[7:0] = b;
            remaining     = held_len;
            rx_phase      = (held_len == 16'd0) ? PH_CRCH : PH_DATA;
         end
         PH_DATA: begin
            crc_acc   = crc16_step(crc_acc, b);
            remaining = remaining - 16'd1;
            if (remaining == 16'd0) rx_phase = PH_CRCH;
            item = '{KIND_PAYLOAD, b, held_cmd, held_len, ST_OK, 1'b0};
            deframed_due.push_back(item);
         end
         PH_CRCH: begin
            crc_hi_byte = b;
            rx_phase    = PH_CRCL;
         end
         default: begin
            verdict = ST_OK;
            if (crc_hi_byte == CrcBypass && b == CrcBypass) verdict = ST_BYPASS;
            else if ({crc_hi_byte, b} != crc_acc) verdict = ST_CRC_ERR;
            // wrong command wins over any CRC outcome
            if (chk_cmd_en && held_cmd != want_cmd) verdict = ST_CMD_MISS;
            item = '{KIND_VERDICT, 8'h00, held_cmd, held_len, verdict, 1'b1};
            deframed_due.push_back(item);
            rx_phase = PH_HUNT1;
         end
      endcase
   endfunction

   task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
      mismatch_count++;
      if (mismatch_count <= MaxReports)
         $display("%0t: %s mismatch, got %0h expected %0h", $realtime, what, got, want);
   endtask

   // mostly back-to-back, some short gaps, rare long ones, now and then a run with none
   function automatic int unsigned pick_gap(inout int unsigned run_left);
      int unsigned r;
      if (run_left > 0) begin
         run_left--;
         return 0;
      end
      r = $urandom_range(999);
      if (r < 5) begin
         run_left = $urandom_range(200, 40);
         return 0;
      end
      if (r < 650) return 0;
      if (r < 920) return $urandom_range(3, 1);
      if (r < 985) return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   // byte driver
   int unsigned send_gap = 0;
   int unsigned send_run = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid   <= 1'b0;
         req_bus.rx_byte <= 8'h00;
         send_gap = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            deframe_byte(req_bus.rx_byte);
            bytes_taken++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_bus.valid <= 1'b0;
            end else if (rx_stream.size() > 0) begin
               req_bus.valid   <= 1'b1;
               req_bus.rx_byte <= rx_stream.pop_front();
               bytes_issued++;
               send_gap = fast_send ? 0 : pick_gap(send_run);
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // result monitor and receiver back-pressure
   int unsigned stall_left = 0;
   int unsigned hold_left  = 0;
   int unsigned sink_run   = 0;

   always @(posedge clock) begin
      frame_out_type due;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (deframed_due.size() == 0) begin
               report_mismatch("unexpected result", {7'd0, rsp_bus.out_kind, rsp_bus.payload_byte},
                               16'd0);
            end else begin
               due = deframed_due.pop_front();
               if (rsp_bus.out_kind !== due.kind)
                  report_mismatch("out_kind", 16'(rsp_bus.out_kind), 16'(due.kind));
               if (rsp_bus.payload_byte !== due.payload)
                  report_mismatch("payload_byte", 16'(rsp_bus.payload_byte), 16'(due.payload));
               if (rsp_bus.frame_command !== due.command)
                  report_mismatch("frame_command", 16'(rsp_bus.frame_command), 16'(due.command));
               if (rsp_bus.frame_length !== due.length)
                  report_mismatch("frame_length", rsp_bus.frame_length, due.length);
               if (rsp_bus.frame_status !== due.status)
                  report_mismatch("frame_status", 16'(rsp_bus.frame_status), 16'(due.status));
               if (rsp_bus.last !== due.last)
                  report_mismatch("last", 16'(rsp_bus.last), 16'(due.last));
            end
         end
         if (hold_seen != hold_asked) begin
            hold_seen = hold_asked;
            hold_left = LongHold;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            stall_left = pick_gap(sink_run);
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (psel && penable)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= IdleLimit) begin
            $display("%0t: watchdog, no transfer for %0d cycles", $realtime, IdleLimit);
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   task automatic push_byte(logic [7:0] b);
      rx_stream.push_back(b);
      bytes_pushed++;
   endtask

   task automatic wait_drained();
      while (rx_stream.size() > 0 || bytes_issued != bytes_taken || deframed_due.size() > 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(reg_index_type idx, logic [CsrDataWidth-1:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (idx == REG_CHECK_COMMAND) chk_cmd_en = value[0];
      else want_cmd = value[7:0];
   endtask

   function automatic logic [7:0] pick_payload();
      logic [7:0] corner [5];
      corner = '{8'h00, 8'hFF, HdrFirst, HdrSecond, CrcBypass};
      if ($urandom_range(9) == 0) return corner[$urandom_range(4)];
      return 8'($urandom);
   endfunction

   task automatic push_frame(logic [7:0] cmd, logic [15:0] len, crc_tail_type tail);
      logic [15:0] crc;
      logic [7:0]  b;
      crc = 16'h0000;
      push_byte(HdrFirst);
      push_byte(HdrSecond);
      push_byte(cmd);
      push_byte(len[15:8]);
      push_byte(len[7:0]);
      for (int unsigned i = 0; i < len; i++) begin
         b   = pick_payload();
         crc = crc16_step(crc, b);
         push_byte(b);
      end
      case (tail)
         CRC_BAD:       crc = crc ^ (16'h0001 << $urandom_range(15));
         CRC_SKIP:      crc = {CrcBypass, CrcBypass};
         CRC_HALF_SKIP: crc = $urandom_range(1) ? {CrcBypass, 8'($urandom)}
                                                : {8'($urandom), CrcBypass};
         default:       ;
      endcase
      push_byte(crc[15:8]);
      push_byte(crc[7:0]);
   endtask

   // noise and broken headers stay clear of a real header so frames keep aligned
   task automatic push_random_frame();
      logic [7:0]   cmd;
      logic [7:0]   b;
      logic [15:0]  len;
      crc_tail_type tail;
      int unsigned  r;
      r = $urandom_range(9);
      if (r == 0) begin
         repeat ($urandom_range(5, 1)) begin
            b = 8'($urandom);
            push_byte(b == HdrFirst ? ~b : b);
         end
      end else if (r == 1) begin
         b = 8'($urandom);
         push_byte(HdrFirst);
         push_byte((b == HdrFirst || b == HdrSecond) ? 8'h00 : b);
      end else if (r == 2) begin
         push_byte(HdrFirst);
      end
      r = $urandom_range(99);
      if (r < 50) cmd = want_cmd;
      else if (r < 60) cmd = 8'h00;
      else if (r < 70) cmd = 8'hFF;
      else cmd = 8'($urandom);
      r = $urandom_range(99);
      if (r < 15) len = 16'd0;
      else if (r < 85) len = 16'($urandom_range(8, 1));
      else len = 16'($urandom_range(48, 9));
      r = $urandom_range(99);
      if (r < 55) tail = CRC_GOOD;
      else if (r < 75) tail = CRC_BAD;
      else if (r < 90) tail = CRC_SKIP;
      else tail = CRC_HALF_SKIP;
      push_frame(cmd, len, tail);
   endtask

   initial begin
      int unsigned phase_start;
      logic        check_v;
      logic [7:0]  exp_v;
      logic [15:0] crc;
      req_bus.valid   = 1'b0;
      req_bus.rx_byte = 8'h00;
      rsp_bus.ready   = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // bad second header byte, then repeated 0x55 into a zero-length frame
      push_byte(HdrFirst);
      push_byte(8'h00);
      push_byte(HdrFirst);
      push_byte(HdrFirst);
      push_byte(HdrSecond);
      repeat (5) push_byte(8'h00);
      // one 0xFF payload byte with a corrupted CRC
      crc = crc16_step(16'h0000, 8'hFF) ^ 16'h0001;
      push_byte(HdrFirst);
      push_byte(HdrSecond);
      push_byte(8'hFF);
      push_byte(8'h00);
      push_byte(8'h01);
      push_byte(8'hFF);
      push_byte(crc[15:8]);
      push_byte(crc[7:0]);
      // CRC bypass on an empty frame
      push_frame(8'h80, 16'd0, CRC_SKIP);
      wait_drained();

      // wrong command with a bad CRC still reads as command mismatch
      csr_write(REG_CHECK_COMMAND, 32'd1);
      csr_write(REG_EXPECTED_COMMAND, 32'h80);
      push_frame(8'h7F, 16'd0, CRC_BAD);
      wait_drained();

      for (int p = 0; p < 8; p++) begin
         check_v = (p % 3 != 2);
         exp_v   = (p == 0) ? 8'h00 : (p == 1) ? 8'hFF : 8'($urandom);
         if (p == 2) begin
            // junk in the unused upper bits
            csr_write(REG_CHECK_COMMAND, ($urandom & ~32'd1) | 32'(check_v));
            csr_write(REG_EXPECTED_COMMAND, {24'($urandom), exp_v});
         end else begin
            csr_write(REG_CHECK_COMMAND, 32'(check_v));
            csr_write(REG_EXPECTED_COMMAND, 32'(exp_v));
         end
         if (p == 3) begin
            // receiver holds off while bytes keep coming, so the input backs up
            fast_send = 1'b1;
            hold_asked++;
            push_frame(want_cmd, 16'd40, CRC_GOOD);
            push_frame(8'($urandom), 16'd12, CRC_BAD);
            wait_drained();
            fast_send = 1'b0;
         end
         if (p == 5) push_frame(want_cmd, 16'd300, CRC_GOOD);
         phase_start = bytes_pushed;
         while (bytes_pushed - phase_start < PhaseBytes) push_random_frame();
         wait_drained();
      end

      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ----- sync_frame_receiver_crc16_top.f -----
+incdir+sv
sv/sfr16_pkg.sv
sv/sfr16_if.sv
sv/sync_frame_receiver_crc16_top.sv
sv/sfr16_checker.sv
verif/sync_frame_receiver_crc16_top_test.sv
